// File: sv/r2s_pkg.sv
package r2s_pkg;

  localparam int SAMPLE_WIDTH = 16;

  // matrix coefficients are scaled by 2^16
  localparam int CX_W = 17;
  localparam int CS_W = 19;

  localparam int P1_W  = SAMPLE_WIDTH + CX_W;
  localparam int XYZ_W = P1_W + 2;
  localparam int P2_W  = XYZ_W + CS_W;
  localparam int LIN_W = P2_W + 2;

  localparam logic signed [CX_W-1:0] TO_XYZ [3][3] = '{
    '{17'sd44137, 17'sd10858, 17'sd8195},
    '{17'sd18287, 17'sd44260, 17'sd2989},
    '{-17'sd127,  17'sd1965,  17'sd52222}
  };

  localparam logic signed [CS_W-1:0] TO_SRGB [3][3] = '{
    '{19'sd212376, -19'sd100742, -19'sd32676},
    '{-19'sd63498, 19'sd122932,  19'sd2720},
    '{19'sd3650,   -19'sd13369,  19'sd69272}
  };

  // root widths of the transfer curve: cube root, then two square roots
  localparam int CR_BITS  = 18;
  localparam int SQ1_BITS = 29;
  localparam int SQ2_BITS = 27;

  localparam int MAT_LAT = 4;
  localparam int ENC_LAT = 1 + CR_BITS + 2 + SQ1_BITS + SQ2_BITS + 2;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] red_in;
    logic signed [SAMPLE_WIDTH-1:0] green_in;
    logic signed [SAMPLE_WIDTH-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] red_out;
    logic [SAMPLE_WIDTH-1:0] green_out;
    logic [SAMPLE_WIDTH-1:0] blue_out;
  } pix_out_t;

endpackage

// File: sv/r2s_encode.sv
module r2s_encode (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [r2s_pkg::LIN_W-1:0]   lin,
  output logic [r2s_pkg::SAMPLE_WIDTH-1:0]   code
);

  localparam int SW      = r2s_pkg::SAMPLE_WIDTH;
  localparam int LIN_W   = r2s_pkg::LIN_W;
  localparam int Q24_SH  = SW + 4;
  localparam int VF_W    = LIN_W - Q24_SH;
  localparam int V_W     = 30;
  localparam int LO_W    = 16;
  localparam int CR_BITS = r2s_pkg::CR_BITS;
  localparam int CN_W    = V_W + 24;
  localparam int CI_W    = CN_W + 2;
  localparam int C3_W    = 2 * CR_BITS + 2;
  localparam int CT_W    = CR_BITS + 2;
  localparam int A2_W    = 2 * CR_BITS - 16;
  localparam int B_W     = V_W + A2_W;
  localparam int R1      = r2s_pkg::SQ1_BITS;
  localparam int Q1_W    = B_W + 8;
  localparam int R2      = r2s_pkg::SQ2_BITS;
  localparam int Q2_W    = 2 * R2;
  localparam int GAIN_W  = 17;
  localparam int GP_W    = R2 + GAIN_W;
  localparam int G_W     = GP_W - 16;
  localparam int SLOPE_W = 20;
  localparam int LP_W    = LO_W + SLOPE_W;
  localparam int SEL_W   = LP_W + 1;
  localparam int LIN_SHIFT = 42 - SW;
  localparam int GAM_SHIFT = 26 - SW;

  localparam logic [V_W-1:0]     V_CAP      = {1'b1, {(V_W-1){1'b0}}};
  localparam logic [V_W-1:0]     V_KNEE     = V_W'(52526);
  localparam logic [SLOPE_W-1:0] SLOPE_Q16  = SLOPE_W'(846725);
  localparam logic [GAIN_W-1:0]  GAIN_Q16   = GAIN_W'(69140);
  localparam logic [G_W-1:0]     OFFSET_Q24 = G_W'(922747);
  localparam logic [SW-1:0]      OUT_MAX    = '1;

  // linear value to Q.24, clamp and cap
  logic [LIN_W-1:0] lin_rnd;
  logic [VF_W-1:0]  v_full;
  logic [V_W-1:0]   v_next;
  logic [V_W-1:0]   v_q;
  logic             knee_q;

  always_comb begin
    lin_rnd = $unsigned(lin) + (LIN_W'(1) << (Q24_SH - 1));
    v_full  = lin_rnd[LIN_W-1:Q24_SH];
    if (lin[LIN_W-1] || lin == '0) begin
      v_next = '0;
    end else if (v_full > VF_W'(V_CAP)) begin
      v_next = V_CAP;
    end else begin
      v_next = v_full[V_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_q    <= v_next;
      knee_q <= (v_next <= V_KNEE);
    end
  end

  // cube root of v << 24, one bit per stage, squares kept as running sums
  logic [CN_W-1:0]    c_rem  [CR_BITS-1];
  logic [C3_W-1:0]    c_s3   [CR_BITS-1];
  logic [CT_W-1:0]    c_t3   [CR_BITS-1];
  logic [CR_BITS-1:0] c_root [CR_BITS];
  logic [V_W-1:0]     c_v    [CR_BITS];
  logic               c_knee [CR_BITS];

  for (genvar k = 0; k < CR_BITS; k++) begin : g_cube
    localparam int J = CR_BITS - 1 - k;
    logic [CN_W-1:0]    rem_i;
    logic [C3_W-1:0]    s3_i;
    logic [CT_W-1:0]    t3_i;
    logic [CR_BITS-1:0] root_i;
    logic [V_W-1:0]     v_i;
    logic               knee_i;
    logic [CI_W-1:0]    inc;
    logic               take;

    if (k == 0) begin : g_head
      assign rem_i  = {v_q, 24'd0};
      assign s3_i   = '0;
      assign t3_i   = '0;
      assign root_i = '0;
      assign v_i    = v_q;
      assign knee_i = knee_q;
    end else begin : g_tail
      assign rem_i  = c_rem[k-1];
      assign s3_i   = c_s3[k-1];
      assign t3_i   = c_t3[k-1];
      assign root_i = c_root[k-1];
      assign v_i    = c_v[k-1];
      assign knee_i = c_knee[k-1];
    end

    // (r + 2^j)^3 - r^3 = 3r^2*2^j + 3r*2^2j + 2^3j
    assign inc  = (CI_W'(s3_i) << J) + (CI_W'(t3_i) << (2 * J)) + (CI_W'(1) << (3 * J));
    assign take = (inc <= CI_W'(rem_i));

    always_ff @(posedge clk) begin
      if (en) begin
        c_root[k] <= take ? (root_i | (CR_BITS'(1) << J)) : root_i;
        c_v[k]    <= v_i;
        c_knee[k] <= knee_i;
      end
    end

    if (k < CR_BITS - 1) begin : g_run
      always_ff @(posedge clk) begin
        if (en) begin
          if (take) begin
            c_rem[k] <= rem_i - inc[CN_W-1:0];
            c_s3[k]  <= s3_i + (C3_W'(t3_i) << (J + 1)) + (C3_W'(3) << (2 * J));
            c_t3[k]  <= t3_i + (CT_W'(3) << J);
          end else begin
            c_rem[k] <= rem_i;
            c_s3[k]  <= s3_i;
            c_t3[k]  <= t3_i;
          end
        end
      end
    end
  end

  // a^2 >> 16, then v * that
  logic [2*CR_BITS-1:0] a_sq;
  logic [A2_W-1:0]      a2h;
  logic [V_W-1:0]       a_v;
  logic                 a_knee;
  logic [B_W-1:0]       b_q;
  logic [LO_W-1:0]      b_lo;
  logic                 b_knee;

  assign a_sq = (2*CR_BITS)'(c_root[CR_BITS-1]) * (2*CR_BITS)'(c_root[CR_BITS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      a2h    <= a_sq[2*CR_BITS-1:16];
      a_v    <= c_v[CR_BITS-1];
      a_knee <= c_knee[CR_BITS-1];
      b_q    <= B_W'(a_v) * B_W'(a2h);
      b_lo   <= a_v[LO_W-1:0];
      b_knee <= a_knee;
    end
  end

  // square root of b << 8
  logic [Q1_W-1:0] s1_rem  [R1-1];
  logic [R1-1:0]   s1_root [R1];
  logic [LO_W-1:0] s1_lo   [R1];
  logic            s1_knee [R1];

  for (genvar k = 0; k < R1; k++) begin : g_sq1
    localparam int J = R1 - 1 - k;
    logic [Q1_W-1:0] rem_i;
    logic [Q1_W-1:0] test;
    logic [R1-1:0]   root_i;
    logic [LO_W-1:0] lo_i;
    logic            knee_i;
    logic            take;

    if (k == 0) begin : g_head
      assign rem_i  = {b_q, 8'd0};
      assign root_i = '0;
      assign lo_i   = b_lo;
      assign knee_i = b_knee;
    end else begin : g_tail
      assign rem_i  = s1_rem[k-1];
      assign root_i = s1_root[k-1];
      assign lo_i   = s1_lo[k-1];
      assign knee_i = s1_knee[k-1];
    end

    assign test = (Q1_W'(root_i) << (J + 1)) | (Q1_W'(1) << (2 * J));
    assign take = (rem_i >= test);

    always_ff @(posedge clk) begin
      if (en) begin
        s1_root[k] <= take ? (root_i | (R1'(1) << J)) : root_i;
        s1_lo[k]   <= lo_i;
        s1_knee[k] <= knee_i;
      end
    end

    if (k < R1 - 1) begin : g_run
      always_ff @(posedge clk) begin
        if (en) begin
          s1_rem[k] <= take ? (rem_i - test) : rem_i;
        end
      end
    end
  end

  // square root of c << 24
  logic [Q2_W-1:0] s2_rem  [R2-1];
  logic [R2-1:0]   s2_root [R2];
  logic [LO_W-1:0] s2_lo   [R2];
  logic            s2_knee [R2];

  for (genvar k = 0; k < R2; k++) begin : g_sq2
    localparam int J = R2 - 1 - k;
    logic [Q2_W-1:0] rem_i;
    logic [Q2_W-1:0] test;
    logic [R2-1:0]   root_i;
    logic [LO_W-1:0] lo_i;
    logic            knee_i;
    logic            take;

    if (k == 0) begin : g_head
      assign rem_i  = Q2_W'({s1_root[R1-1], 24'd0});
      assign root_i = '0;
      assign lo_i   = s1_lo[R1-1];
      assign knee_i = s1_knee[R1-1];
    end else begin : g_tail
      assign rem_i  = s2_rem[k-1];
      assign root_i = s2_root[k-1];
      assign lo_i   = s2_lo[k-1];
      assign knee_i = s2_knee[k-1];
    end

    assign test = (Q2_W'(root_i) << (J + 1)) | (Q2_W'(1) << (2 * J));
    assign take = (rem_i >= test);

    always_ff @(posedge clk) begin
      if (en) begin
        s2_root[k] <= take ? (root_i | (R2'(1) << J)) : root_i;
        s2_lo[k]   <= lo_i;
        s2_knee[k] <= knee_i;
      end
    end

    if (k < R2 - 1) begin : g_run
      always_ff @(posedge clk) begin
        if (en) begin
          s2_rem[k] <= take ? (rem_i - test) : rem_i;
        end
      end
    end
  end

  // gain and slope products
  logic [GP_W-1:0] m_gp;
  logic [LP_W-1:0] m_lp;
  logic            m_knee;

  always_ff @(posedge clk) begin
    if (en) begin
      m_gp   <= GP_W'(s2_root[R2-1]) * GP_W'(GAIN_Q16);
      m_lp   <= LP_W'(s2_lo[R2-1]) * LP_W'(SLOPE_Q16);
      m_knee <= s2_knee[R2-1];
    end
  end

  // offset, rounding, branch select, saturation
  logic [GP_W-1:0]  g_rnd;
  logic [G_W-1:0]   g;
  logic [G_W-1:0]   e;
  logic [SEL_W-1:0] og;
  logic [SEL_W-1:0] ol;
  logic [SEL_W-1:0] sel;
  logic [SW-1:0]    code_next;

  always_comb begin
    g_rnd     = m_gp + (GP_W'(1) << 15);
    g         = g_rnd[GP_W-1:16];
    e         = (g > OFFSET_Q24) ? (g - OFFSET_Q24) : '0;
    og        = (SEL_W'(e) + (SEL_W'(1) << (GAM_SHIFT - 1))) >> GAM_SHIFT;
    ol        = (SEL_W'(m_lp) + (SEL_W'(1) << (LIN_SHIFT - 1))) >> LIN_SHIFT;
    sel       = m_knee ? ol : og;
    code_next = (sel > SEL_W'(OUT_MAX)) ? OUT_MAX : sel[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code <= code_next;
    end
  end

endmodule

// File: sv/rec2020_to_srgb_gamma_unit.sv
// Converts one linear Rec.2020 pixel (signed Q3.12 per component) to one
// gamma-encoded sRGB pixel (unsigned Q2.14, saturating) per item, through the
// Rec.2020-to-XYZ and XYZ-to-sRGB matrices, a clamp of negatives and the sRGB
// transfer curve. The datapath is a fixed pipeline of 83 stages: 4 for the two
// matrices, then per channel the curve, whose cube root and two square roots
// each resolve one result bit per stage. One pixel enters every clock while
// lin_ready is high, so throughput is one item per cycle unless the output
// stalls. An item passes through the 83 pipeline stages and then the two-entry
// output buffer. lin_ready is decoded straight from the buffer count and drops
// only while that buffer holds two items, and the whole pipeline then holds.
module rec2020_to_srgb_gamma_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               lin_valid,
  output logic               lin_ready,
  input  r2s_pkg::pix_in_t   lin_pix,
  output logic               srgb_valid,
  input  logic               srgb_ready,
  output r2s_pkg::pix_out_t  srgb_pix
);

  localparam int SW    = r2s_pkg::SAMPLE_WIDTH;
  localparam int P1_W  = r2s_pkg::P1_W;
  localparam int XYZ_W = r2s_pkg::XYZ_W;
  localparam int P2_W  = r2s_pkg::P2_W;
  localparam int LIN_W = r2s_pkg::LIN_W;
  localparam int DEPTH = r2s_pkg::MAT_LAT + r2s_pkg::ENC_LAT;

  localparam logic [1:0] SKID_EMPTY = 2'd0;
  localparam logic [1:0] SKID_FULL  = 2'd2;

  logic             en;
  logic [DEPTH-1:0] vld;
  logic [1:0]       cnt;
  logic [1:0]       cnt_next;
  logic             wr;
  logic             rd;

  assign en        = (cnt != SKID_FULL);
  assign lin_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], lin_valid};
    end
  end

  // color matrices
  logic signed [SW-1:0]    x     [3];
  logic signed [P1_W-1:0]  p1    [3][3];
  logic signed [XYZ_W-1:0] xyz   [3];
  logic signed [P2_W-1:0]  p2    [3][3];
  logic signed [LIN_W-1:0] lin_q [3];

  assign x[0] = lin_pix.red_in;
  assign x[1] = lin_pix.green_in;
  assign x[2] = lin_pix.blue_in;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          p1[i][k] <= P1_W'(x[k]) * P1_W'(r2s_pkg::TO_XYZ[i][k]);
          p2[i][k] <= P2_W'(xyz[k]) * P2_W'(r2s_pkg::TO_SRGB[i][k]);
        end
        xyz[i]   <= XYZ_W'(p1[i][0]) + XYZ_W'(p1[i][1]) + XYZ_W'(p1[i][2]);
        lin_q[i] <= LIN_W'(p2[i][0]) + LIN_W'(p2[i][1]) + LIN_W'(p2[i][2]);
      end
    end
  end

  // transfer curve per channel
  logic [SW-1:0] code [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    r2s_encode u_enc (
      .clk  (clk),
      .en   (en),
      .lin  (lin_q[c]),
      .code (code[c])
    );
  end

  // two-entry output buffer
  r2s_pkg::pix_out_t wpix;
  r2s_pkg::pix_out_t buf0;
  r2s_pkg::pix_out_t buf1;

  assign wpix.red_out   = code[0];
  assign wpix.green_out = code[1];
  assign wpix.blue_out  = code[2];

  assign wr         = en && vld[DEPTH-1];
  assign srgb_valid = (cnt != SKID_EMPTY);
  assign rd         = srgb_valid && srgb_ready;
  assign srgb_pix   = buf0;
  assign cnt_next   = cnt + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= SKID_EMPTY;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      if (cnt == SKID_FULL) begin
        buf0 <= buf1;
      end else if (wr) begin
        buf0 <= wpix;
      end
    end else if (wr) begin
      if (cnt == SKID_EMPTY) begin
        buf0 <= wpix;
      end else begin
        buf1 <= wpix;
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int SW = r2s_pkg::SAMPLE_WIDTH;
  localparam longint unsigned OUT_MAX = (64'd1 << SW) - 1;
  localparam longint unsigned V_CAP = 64'd1 << 29;
  localparam longint unsigned V_KNEE = 52526;
  localparam longint unsigned SLOPE_Q16 = 846725;
  localparam longint unsigned GAIN_Q16 = 69140;
  localparam longint unsigned OFFSET_Q24 = 922747;
  localparam int N_RANDOM = 1950;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic lin_valid = 1'b0;
  logic lin_ready;
  r2s_pkg::pix_in_t lin_pix = '0;
  logic srgb_valid;
  logic srgb_ready = 1'b0;
  r2s_pkg::pix_out_t srgb_pix;

  r2s_pkg::pix_in_t pixel_q[$];
  r2s_pkg::pix_out_t srgb_exp_q[$];
  int n_total = 0;
  int n_sent = 0;
  int n_err = 0;

  rec2020_to_srgb_gamma_unit dut (
    .clk        (clk),
    .rst        (rst),
    .lin_valid  (lin_valid),
    .lin_ready  (lin_ready),
    .lin_pix    (lin_pix),
    .srgb_valid (srgb_valid),
    .srgb_ready (srgb_ready),
    .srgb_pix   (srgb_pix)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned isqrt64(input longint unsigned n);
    longint unsigned r, c;
    int bit_i;
    r = 0;
    for (bit_i = 31; bit_i >= 0; bit_i--) begin
      c = r | (64'd1 << bit_i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint unsigned icbrt64(input longint unsigned n);
    longint unsigned r, c;
    int bit_i;
    r = 0;
    for (bit_i = 18; bit_i >= 0; bit_i--) begin
      c = r | (64'd1 << bit_i);
      if (c * c * c <= n) r = c;
    end
    return r;
  endfunction

  // linear sRGB (exact, 32+SW-4 fraction bits) to gamma-encoded code
  function automatic logic [SW-1:0] srgb_encode(input longint lin);
    longint unsigned v, o, a, b, c, d, g, e;
    if (lin <= 0) return '0;
    v = (longint'(lin) + (64'd1 << (SW + 3))) >> (SW + 4);
    if (v > V_CAP) v = V_CAP;
    if (v <= V_KNEE) begin
      o = (v * SLOPE_Q16 + (64'd1 << (41 - SW))) >> (42 - SW);
    end else begin
      a = icbrt64(v << 24);
      b = v * ((a * a) >> 16);
      c = isqrt64(b << 8);
      d = isqrt64(c << 24);
      g = (d * GAIN_Q16 + (64'd1 << 15)) >> 16;
      e = (g > OFFSET_Q24) ? g - OFFSET_Q24 : 64'd0;
      o = (e + (64'd1 << (25 - SW))) >> (26 - SW);
    end
    if (o > OUT_MAX) o = OUT_MAX;
    return o[SW-1:0];
  endfunction

  function automatic r2s_pkg::pix_out_t predict_srgb(input r2s_pkg::pix_in_t p);
    longint r, g, b, cx, cy, cz;
    r2s_pkg::pix_out_t q;
    r = longint'(p.red_in);
    g = longint'(p.green_in);
    b = longint'(p.blue_in);
    cx = 44137 * r + 10858 * g + 8195 * b;
    cy = 18287 * r + 44260 * g + 2989 * b;
    cz = -127 * r + 1965 * g + 52222 * b;
    q.red_out   = srgb_encode(212376 * cx - 100742 * cy - 32676 * cz);
    q.green_out = srgb_encode(-63498 * cx + 122932 * cy + 2720 * cz);
    q.blue_out  = srgb_encode(3650 * cx - 13369 * cy + 69272 * cz);
    return q;
  endfunction

  // idle rates: sender light / receiver heavy, then swapped, then none
  function automatic int send_idle_pct();
    if (n_sent < n_total / 3) return 8;
    if (n_sent < 2 * n_total / 3) return 59;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_sent < n_total / 3) return 59;
    if (n_sent < 2 * n_total / 3) return 8;
    return 0;
  endfunction

  task automatic add_pix(input int r, input int g, input int b);
    r2s_pkg::pix_in_t p;
    p.red_in = r[SW-1:0];
    p.green_in = g[SW-1:0];
    p.blue_in = b[SW-1:0];
    pixel_q.push_back(p);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lin_valid <= 1'b0;
    end else begin
      if (lin_valid && lin_ready) begin
        srgb_exp_q.push_back(predict_srgb(lin_pix));
      end
      if (!lin_valid || lin_ready) begin
        if (pixel_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          lin_pix <= pixel_q.pop_front();
          lin_valid <= 1'b1;
          n_sent++;
        end else begin
          lin_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      srgb_ready <= 1'b0;
    end else begin
      srgb_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    r2s_pkg::pix_out_t want;
    if (!rst && srgb_valid && srgb_ready) begin
      if (srgb_exp_q.size() == 0) begin
        if (n_err < 10) $display("unexpected item: r=%0d g=%0d b=%0d",
                                 srgb_pix.red_out, srgb_pix.green_out, srgb_pix.blue_out);
        n_err++;
      end else begin
        want = srgb_exp_q.pop_front();
        if (srgb_pix !== want) begin
          if (n_err < 10) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red_out, want.green_out, want.blue_out,
                     srgb_pix.red_out, srgb_pix.green_out, srgb_pix.blue_out);
          end
          n_err++;
        end
      end
    end
  end

  initial begin
    int i, sel, r, g, b;
    // directed: extremes, white, primaries, values around the knee, negatives
    add_pix(0, 0, 0);
    add_pix(32767, 32767, 32767);
    add_pix(-32768, -32768, -32768);
    add_pix(4096, 4096, 4096);
    add_pix(4096, 0, 0);
    add_pix(0, 4096, 0);
    add_pix(0, 0, 4096);
    add_pix(1, 1, 1);
    add_pix(2, 2, 2);
    add_pix(12, 12, 12);
    add_pix(13, 13, 13);
    add_pix(14, 14, 14);
    add_pix(-1, -1, -1);
    add_pix(32767, -32768, -32768);
    add_pix(-32768, 32767, -32768);
    add_pix(-32768, -32768, 32767);
    add_pix(32767, 0, 0);
    add_pix(0, 32767, 0);
    add_pix(0, 0, 32767);
    add_pix(16384, 16384, 16384);
    add_pix(-4096, 4096, 4096);
    add_pix(21845, -21846, 10922);
    for (i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        r = $urandom; g = $urandom; b = $urandom;
      end else if (sel < 7) begin
        r = $urandom_range(0, 4096); g = $urandom_range(0, 4096); b = $urandom_range(0, 4096);
      end else if (sel == 7) begin
        r = $urandom_range(0, 40); g = r + $urandom_range(0, 4); b = r + $urandom_range(0, 4);
      end else if (sel == 8) begin
        r = $urandom_range(0, 8192) - 4096;
        g = $urandom_range(0, 8192) - 4096;
        b = $urandom_range(0, 8192) - 4096;
      end else begin
        r = $urandom_range(0, 32767); g = r; b = r;
      end
      add_pix(r, g, b);
    end
    n_total = pixel_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0 || lin_valid || srgb_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
sv/r2s_pkg.sv
sv/r2s_encode.sv
sv/rec2020_to_srgb_gamma_unit.sv
tb/sv/tb_top.sv
